// ----- hw/rtl/csbp_pkg.sv -----
// Shared constants and types for the contour skyline block packer.
package csbp_pkg;

    // Contour geometry and height range
    localparam int CONTOUR_COLUMNS = 1024;
    localparam int HEIGHT_BITS     = 16;
    localparam int COL_BITS        = $clog2(CONTOUR_COLUMNS);
    localparam int CUR_BITS        = COL_BITS + 1;

    // Floorplan epoch tag kept next to every contour entry
    localparam int EPOCH_BITS      = 8;
    localparam int ENTRY_BITS      = EPOCH_BITS + HEIGHT_BITS;

    // Fixed field widths of the item and result channels
    localparam int OP_BITS     = 2;
    localparam int BW_BITS     = 11;
    localparam int BH_BITS     = 15;
    localparam int PX_BITS     = 10;
    localparam int PY_BITS     = 16;
    localparam int EX_BITS     = 11;
    localparam int EY_BITS     = 16;
    localparam int AREA_BITS   = 26;

    // Widths of the bound checks
    localparam int WSUM_BITS   = ((CUR_BITS > BW_BITS) ? CUR_BITS : BW_BITS) + 1;
    localparam int HSUM_BITS   = ((HEIGHT_BITS > BH_BITS) ? HEIGHT_BITS : BH_BITS) + 1;
    localparam int PROD_BITS   = CUR_BITS + HEIGHT_BITS;

    typedef logic [OP_BITS-1:0]     op_t;
    typedef logic [BW_BITS-1:0]     bw_t;
    typedef logic [BH_BITS-1:0]     bh_t;
    typedef logic [PX_BITS-1:0]     px_t;
    typedef logic [PY_BITS-1:0]     py_t;
    typedef logic [EX_BITS-1:0]     ex_t;
    typedef logic [EY_BITS-1:0]     ey_t;
    typedef logic [AREA_BITS-1:0]   area_t;
    typedef logic [COL_BITS-1:0]    col_t;
    typedef logic [CUR_BITS-1:0]    cur_t;
    typedef logic [HEIGHT_BITS-1:0] hgt_t;
    typedef logic [EPOCH_BITS-1:0]  epoch_t;
    typedef logic [WSUM_BITS-1:0]   wsum_t;
    typedef logic [HSUM_BITS-1:0]   hsum_t;
    typedef logic [PROD_BITS-1:0]   prod_t;

    typedef struct packed {
        epoch_t epoch;
        hgt_t   height;
    } entry_t;

    // Operation codes; the unused code behaves as a row continuation
    localparam op_t OP_CONTINUE  = 2'd0;
    localparam op_t OP_NEW_ROW   = 2'd1;
    localparam op_t OP_NEW_PLAN  = 2'd2;

    // Bounds
    localparam wsum_t  COLUMNS_SUM  = wsum_t'(CONTOUR_COLUMNS);
    localparam col_t   COL_LAST     = col_t'(CONTOUR_COLUMNS - 1);
    localparam hsum_t  HEIGHT_LIMIT = {{(HSUM_BITS-HEIGHT_BITS){1'b0}}, {HEIGHT_BITS{1'b1}}};
    localparam epoch_t EPOCH_FIRST  = epoch_t'(1);
    localparam epoch_t EPOCH_STALE  = epoch_t'(0);

endpackage

// ----- hw/rtl/contour_skyline_block_packer_unit.sv -----
// Top level of the contour skyline block packer: sequencer around the contour RAM.
//
// Places blocks left to right in rows on a 1024-column skyline contour held in one
// synchronous RAM, one column per cycle. An item that places a block runs these steps
// from acceptance to result: read the covered columns and find the highest, drain the
// read, check the height bound, write the raised columns back, load the result
// register. The input is ready again in the cycle after the result is loaded. An item
// rejected for width skips the contour scan and write-back; one rejected for height
// goes to its result after the height check. New floorplans retag the contour instead
// of clearing it; every 255th new floorplan, and the period right after reset, runs a
// clearing pass over all 1024 columns during which no item is taken. The result
// register lets the next item enter while a result waits to be taken.
module contour_skyline_block_packer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csbp_pkg::op_t       operation,
    input  csbp_pkg::bw_t       block_width,
    input  csbp_pkg::bh_t       block_height,
    output logic                out_valid,
    input  logic                out_ready,
    output csbp_pkg::px_t       place_x,
    output csbp_pkg::py_t       place_y,
    output csbp_pkg::ex_t       extent_x,
    output csbp_pkg::ey_t       extent_y,
    output csbp_pkg::area_t     bounding_area,
    output logic                overflow
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EVAL,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic               init_reg;
    csbp_pkg::epoch_t   epoch_reg;
    csbp_pkg::col_t     sweep_reg;
    csbp_pkg::cur_t     cursor_reg;
    csbp_pkg::cur_t     max_x_reg;
    csbp_pkg::hgt_t     max_y_reg;
    csbp_pkg::col_t     start_reg;
    csbp_pkg::col_t     addr_reg;
    csbp_pkg::bw_t      cnt_reg;
    csbp_pkg::bw_t      w_reg;
    csbp_pkg::bh_t      h_reg;
    csbp_pkg::hgt_t     top_reg;
    csbp_pkg::hgt_t     newtop_reg;
    logic               pend_reg;
    logic               bad_reg;
    logic               out_valid_reg;
    csbp_pkg::px_t      place_x_reg;
    csbp_pkg::py_t      place_y_reg;
    csbp_pkg::ex_t      extent_x_reg;
    csbp_pkg::ey_t      extent_y_reg;
    csbp_pkg::area_t    area_reg;
    logic               overflow_reg;

    csbp_pkg::cur_t     eff_cursor;
    csbp_pkg::wsum_t    wsum;
    logic               width_bad;
    logic               new_plan;
    logic               epoch_wrap;
    csbp_pkg::entry_t   rd_entry;
    csbp_pkg::hgt_t     rd_height;
    csbp_pkg::hsum_t    hsum;
    logic               height_bad;
    csbp_pkg::cur_t     new_right;
    csbp_pkg::prod_t    prod;
    logic               ram_we;
    csbp_pkg::col_t     ram_waddr;
    csbp_pkg::entry_t   ram_wdata;
    logic [csbp_pkg::ENTRY_BITS-1:0] ram_rdata;

    // Count value of one in the width counter
    function automatic csbp_pkg::bw_t bw_one();
        return csbp_pkg::bw_t'(1);
    endfunction

    // Contour storage: epoch tag and height per column
    csbp_ram #(
        .WIDTH (csbp_pkg::ENTRY_BITS),
        .DEPTH (csbp_pkg::CONTOUR_COLUMNS)
    ) u_contour (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Apply the row or floorplan request and check the row width
    assign new_plan   = (operation == csbp_pkg::OP_NEW_PLAN);
    assign eff_cursor = (operation == csbp_pkg::OP_NEW_ROW || new_plan) ? '0 : cursor_reg;
    assign wsum       = csbp_pkg::wsum_t'(eff_cursor) + csbp_pkg::wsum_t'(block_width);
    assign width_bad  = (block_width == '0) || (wsum > csbp_pkg::COLUMNS_SUM);
    assign epoch_wrap = (epoch_reg == '1);

    // Treat entries from an older floorplan as ground level
    assign rd_entry  = csbp_pkg::entry_t'(ram_rdata);
    assign rd_height = (rd_entry.epoch == epoch_reg) ? rd_entry.height : '0;

    // Height bound and new row edge
    assign hsum       = csbp_pkg::hsum_t'(top_reg) + csbp_pkg::hsum_t'(h_reg);
    assign height_bad = (hsum > csbp_pkg::HEIGHT_LIMIT);
    assign new_right  = csbp_pkg::cur_t'(csbp_pkg::wsum_t'(cursor_reg)
                                         + csbp_pkg::wsum_t'(w_reg));

    // Bounding area from the settled extents
    assign prod = csbp_pkg::prod_t'(max_x_reg) * csbp_pkg::prod_t'(max_y_reg);

    // Drive the write port from the sweep or the write-back
    always_comb
    begin
        ram_we    = (state_reg == S_SWEEP) || (state_reg == S_WRITE);
        ram_waddr = (state_reg == S_SWEEP) ? sweep_reg : addr_reg;
        if (state_reg == S_SWEEP)
        begin
            ram_wdata.epoch  = csbp_pkg::EPOCH_STALE;
            ram_wdata.height = '0;
        end
        else
        begin
            ram_wdata.epoch  = epoch_reg;
            ram_wdata.height = newtop_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign place_x       = place_x_reg;
    assign place_y       = place_y_reg;
    assign extent_x      = extent_x_reg;
    assign extent_y      = extent_y_reg;
    assign bounding_area = area_reg;
    assign overflow      = overflow_reg;

    // Sequence one item: clear the contour when needed, scan, check, write back, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            init_reg      <= 1'b1;
            epoch_reg     <= csbp_pkg::EPOCH_FIRST;
            sweep_reg     <= '0;
            cursor_reg    <= '0;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            start_reg     <= '0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            top_reg       <= '0;
            newtop_reg    <= '0;
            pend_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            place_x_reg   <= '0;
            place_y_reg   <= '0;
            extent_x_reg  <= '0;
            extent_y_reg  <= '0;
            area_reg      <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless the next one is loaded now
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == csbp_pkg::COL_LAST)
                    begin
                        init_reg <= 1'b0;
                        if (init_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (bad_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        w_reg      <= block_width;
                        h_reg      <= block_height;
                        cnt_reg    <= block_width;
                        addr_reg   <= csbp_pkg::col_t'(eff_cursor);
                        start_reg  <= csbp_pkg::col_t'(eff_cursor);
                        cursor_reg <= eff_cursor;
                        bad_reg    <= width_bad;
                        top_reg    <= '0;
                        pend_reg   <= 1'b0;
                        sweep_reg  <= '0;
                        if (new_plan)
                        begin
                            max_x_reg <= '0;
                            max_y_reg <= '0;
                            epoch_reg <= epoch_wrap ? csbp_pkg::EPOCH_FIRST
                                                    : epoch_reg + 1'b1;
                        end
                        if (new_plan && epoch_wrap)
                        begin
                            state_reg <= S_SWEEP;
                        end
                        else if (width_bad)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end

                S_READ:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    cnt_reg  <= cnt_reg - 1'b1;
                    pend_reg <= 1'b1;
                    if (pend_reg && rd_height > top_reg)
                    begin
                        top_reg <= rd_height;
                    end
                    if (cnt_reg == bw_one())
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    pend_reg <= 1'b0;
                    if (rd_height > top_reg)
                    begin
                        top_reg <= rd_height;
                    end
                    state_reg <= S_EVAL;
                end

                S_EVAL:
                begin
                    if (height_bad)
                    begin
                        bad_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        newtop_reg <= csbp_pkg::hgt_t'(hsum);
                        addr_reg   <= start_reg;
                        cnt_reg    <= w_reg;
                        cursor_reg <= new_right;
                        if (new_right > max_x_reg)
                        begin
                            max_x_reg <= new_right;
                        end
                        if (csbp_pkg::hgt_t'(hsum) > max_y_reg)
                        begin
                            max_y_reg <= csbp_pkg::hgt_t'(hsum);
                        end
                        state_reg <= S_WRITE;
                    end
                end

                S_WRITE:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == bw_one())
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        place_x_reg   <= bad_reg ? '0 : csbp_pkg::px_t'(start_reg);
                        place_y_reg   <= bad_reg ? '0 : csbp_pkg::py_t'(top_reg);
                        extent_x_reg  <= csbp_pkg::ex_t'(max_x_reg);
                        extent_y_reg  <= csbp_pkg::ey_t'(max_y_reg);
                        area_reg      <= csbp_pkg::area_t'(prod);
                        overflow_reg  <= bad_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // An accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // Row cursor never passes the contour edge
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= csbp_pkg::cur_t'(csbp_pkg::CONTOUR_COLUMNS))
        else $error("row cursor beyond contour");

    // Right extent always covers the cursor
    a_extent_covers_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        max_x_reg >= cursor_reg)
        else $error("right extent behind row cursor");

    // Rejected blocks report no placement
    a_reject_zero_place: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> place_x == '0 && place_y == '0)
        else $error("rejected block reports a placement");

    // Live epoch never matches the tag of cleared entries
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != csbp_pkg::EPOCH_STALE)
        else $error("epoch equals cleared tag");
`endif

endmodule

// ----- hw/rtl/csbp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module csbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the contour skyline block packer unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The spare operation code acts as a row continuation
    localparam csbp_pkg::op_t OP_RESERVED = 2'd3;
    localparam int  HEIGHT_MAX   = (1 << csbp_pkg::HEIGHT_BITS) - 1;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 2 * csbp_pkg::CONTOUR_COLUMNS + 16;
    localparam int  TURNOVER_PLANS = 270;
    localparam int  RANDOM_ITEMS   = 340;

    typedef struct packed {
        csbp_pkg::px_t   x;
        csbp_pkg::py_t   y;
        csbp_pkg::ex_t   ex;
        csbp_pkg::ey_t   ey;
        csbp_pkg::area_t area;
        logic            ovf;
    } placement_t;

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            in_valid      = 1'b0;
    logic            in_ready;
    csbp_pkg::op_t   operation     = csbp_pkg::OP_CONTINUE;
    csbp_pkg::bw_t   block_width   = '0;
    csbp_pkg::bh_t   block_height  = '0;
    logic            out_valid;
    logic            out_ready     = 1'b0;
    csbp_pkg::px_t   place_x;
    csbp_pkg::py_t   place_y;
    csbp_pkg::ex_t   extent_x;
    csbp_pkg::ey_t   extent_y;
    csbp_pkg::area_t bounding_area;
    logic            overflow;

    // Contour and floorplan state mirrored by the placement predictor
    csbp_pkg::hgt_t contour_height [csbp_pkg::CONTOUR_COLUMNS] = '{default: '0};
    csbp_pkg::cur_t cursor     = '0;
    csbp_pkg::ex_t  right_edge = '0;
    csbp_pkg::ey_t  top_edge   = '0;

    placement_t pending_placements[$];
    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;
    int in_gap_max     = 3;
    int out_stall_max  = 3;

    contour_skyline_block_packer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .block_width   (block_width),
        .block_height  (block_height),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .place_x       (place_x),
        .place_y       (place_y),
        .extent_x      (extent_x),
        .extent_y      (extent_y),
        .bounding_area (bounding_area),
        .overflow      (overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bound the run in case the block hangs or drops an item
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_placements.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Place one block on the mirrored contour and return the result it yields
    function automatic placement_t pack_block(csbp_pkg::op_t op, csbp_pkg::bw_t w,
                                              csbp_pkg::bh_t h);
        placement_t res;
        int cur_i;
        int w_i;
        int peak;
        int col;
        logic bad;
        res  = '0;
        bad  = 1'b0;
        peak = 0;
        if (op == csbp_pkg::OP_NEW_PLAN)
        begin
            foreach (contour_height[i])
                contour_height[i] = '0;
            cursor     = '0;
            right_edge = '0;
            top_edge   = '0;
        end
        else if (op == csbp_pkg::OP_NEW_ROW)
        begin
            cursor = '0;
        end
        cur_i = int'(cursor);
        w_i   = int'(w);
        if (w_i == 0 || cur_i + w_i > csbp_pkg::CONTOUR_COLUMNS)
        begin
            bad = 1'b1;
        end
        else
        begin
            // Find the highest contour under the block
            for (col = cur_i; col < cur_i + w_i; col++)
                if (int'(contour_height[col]) > peak)
                    peak = int'(contour_height[col]);
            if (peak + int'(h) > HEIGHT_MAX)
            begin
                bad = 1'b1;
            end
            else
            begin
                // Raise the covered columns and advance the row
                for (col = cur_i; col < cur_i + w_i; col++)
                    contour_height[col] = csbp_pkg::hgt_t'(peak + int'(h));
                res.x  = csbp_pkg::px_t'(cur_i);
                res.y  = csbp_pkg::py_t'(peak);
                cursor = csbp_pkg::cur_t'(cur_i + w_i);
                if (cursor > right_edge)
                    right_edge = cursor;
                if (peak + int'(h) > int'(top_edge))
                    top_edge = csbp_pkg::ey_t'(peak + int'(h));
            end
        end
        res.ex   = right_edge;
        res.ey   = top_edge;
        res.area = csbp_pkg::area_t'(longint'(right_edge) * longint'(top_edge));
        res.ovf  = bad;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item, hold it until accepted, then record its placement
    task automatic send_block(csbp_pkg::op_t op, csbp_pkg::bw_t w, csbp_pkg::bh_t h);
        int gap;
        placement_t expected;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        block_width  <= w;
        block_height <= h;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected = pack_block(op, w, h);
        pending_placements.insert(pending_placements.size(), expected);
    endtask

    // Mostly widths that fit the rest of the row, some zero or past the edge
    function automatic csbp_pkg::bw_t draw_width(int room);
        int pick;
        int hi;
        pick = $urandom_range(0, 39);
        hi   = (room < 1) ? 48 : ((room < 48) ? room : 48);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return csbp_pkg::bw_t'($urandom_range(csbp_pkg::CONTOUR_COLUMNS + 1, 2047));
        if (pick == 2)
            return csbp_pkg::bw_t'(room);
        if (pick == 3)
            return csbp_pkg::bw_t'(room + $urandom_range(1, 4));
        return csbp_pkg::bw_t'($urandom_range(1, hi));
    endfunction

    // Mostly short blocks, now and then tall or flat ones
    function automatic csbp_pkg::bh_t draw_height();
        int pick;
        pick = $urandom_range(0, 31);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick < 4)
            return csbp_pkg::bh_t'($urandom_range(8192, 32767));
        return csbp_pkg::bh_t'($urandom_range(1, 400));
    endfunction

    // Field extremes, every operation and each rejection path
    task automatic test_directed_corners();
        in_gap_max    = 3;
        out_stall_max = 3;
        // Place on the contour left by reset, with no floorplan opened yet
        send_block(csbp_pkg::OP_CONTINUE, 11'd1, 15'd1);
        send_block(csbp_pkg::OP_NEW_PLAN, 11'd1, 15'd1);
        send_block(csbp_pkg::OP_CONTINUE, 11'd1023, 15'h7FFF);
        // Row full: any further block is too wide
        send_block(csbp_pkg::OP_CONTINUE, 11'd1, 15'd1);
        send_block(csbp_pkg::OP_NEW_ROW, 11'd1024, 15'h7FFF);
        // Reach the height limit exactly, then go past it
        send_block(csbp_pkg::OP_NEW_ROW, 11'd1, 15'd1);
        send_block(csbp_pkg::OP_NEW_ROW, 11'd2, 15'd0);
        send_block(csbp_pkg::OP_NEW_ROW, 11'd3, 15'd1);
        // Rejected new row still rewinds the cursor
        send_block(OP_RESERVED, 11'd2, 15'd0);
        // Zero width on a new floorplan: rejected, but the plan is cleared
        send_block(csbp_pkg::OP_NEW_PLAN, 11'd0, 15'd5);
        send_block(OP_RESERVED, 11'd682, 15'h2AAA);
        send_block(csbp_pkg::OP_CONTINUE, 11'h7FF, 15'h5555);
        send_block(csbp_pkg::OP_CONTINUE, 11'd342, 15'h5555);
        send_block(csbp_pkg::OP_NEW_ROW, 11'h555, 15'd1);
        send_block(csbp_pkg::OP_CONTINUE, 11'd1024, 15'h7FFF);
        send_block(csbp_pkg::OP_NEW_PLAN, 11'd1025, 15'd1);
        // Uneven steps: the next row lands on the highest one
        send_block(csbp_pkg::OP_NEW_ROW, 11'd16, 15'd100);
        send_block(csbp_pkg::OP_CONTINUE, 11'd8, 15'd50);
        send_block(csbp_pkg::OP_NEW_ROW, 11'd20, 15'd7);
        send_block(csbp_pkg::OP_NEW_ROW, 11'd1, 15'h7FFF);
    endtask

    // Open many floorplans so old contour data must never show through
    task automatic test_floorplan_turnover();
        int p;
        for (p = 0; p < TURNOVER_PLANS; p++)
        begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 3;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            send_block(csbp_pkg::OP_NEW_PLAN, csbp_pkg::bw_t'($urandom_range(1, 48)),
                       draw_height());
            if ($urandom_range(0, 1) == 1)
                send_block(csbp_pkg::OP_CONTINUE,
                           draw_width(csbp_pkg::CONTOUR_COLUMNS - int'(cursor)),
                           draw_height());
        end
    endtask

    // Rows of blocks with random content, some broken starts and stray operations
    task automatic test_random_rows();
        int            items;
        int            n;
        int            k;
        int            pick;
        csbp_pkg::op_t op;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 3;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            pick = $urandom_range(0, 15);
            if (pick < 2)
                op = csbp_pkg::OP_NEW_PLAN;
            else if (pick == 2)
                op = csbp_pkg::OP_CONTINUE;
            else
                op = csbp_pkg::OP_NEW_ROW;
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
            begin
                if (k > 0)
                begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        op = csbp_pkg::OP_NEW_PLAN;
                    else if (pick < 3)
                        op = OP_RESERVED;
                    else
                        op = csbp_pkg::OP_CONTINUE;
                end
                if (op == csbp_pkg::OP_NEW_PLAN || op == csbp_pkg::OP_NEW_ROW)
                    send_block(op, draw_width(csbp_pkg::CONTOUR_COLUMNS), draw_height());
                else
                    send_block(op, draw_width(csbp_pkg::CONTOUR_COLUMNS - int'(cursor)),
                               draw_height());
                items++;
            end
        end
    endtask

    // Take results with random stalls and compare them against the predictions
    initial
    begin : result_checker
        placement_t want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (pending_placements.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = pending_placements.pop_front();
                if (place_x !== want.x)
                    report_mismatch("place_x", place_x, want.x);
                if (place_y !== want.y)
                    report_mismatch("place_y", place_y, want.y);
                if (extent_x !== want.ex)
                    report_mismatch("extent_x", extent_x, want.ex);
                if (extent_y !== want.ey)
                    report_mismatch("extent_y", extent_y, want.ey);
                if (bounding_area !== want.area)
                    report_mismatch("bounding_area", bounding_area, want.area);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
            end
            result_count++;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_floorplan_turnover();
        test_random_rows();
        in_valid <= 1'b0;
        // Drain outstanding results, then watch for stray ones
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
